>>> sv/wsm_pkg.sv
// Shared types, constants and register codes for the wildcard star pattern matcher.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package wsm_pkg;

    // Pattern size as built, and the number of token slots the registers can describe.
    localparam int MAX_TOKENS      = 16;
    localparam int TOKEN_SLOTS     = 16;
    localparam int NUM_CELLS       = (MAX_TOKENS < TOKEN_SLOTS) ? MAX_TOKENS : TOKEN_SLOTS;
    localparam int COL_W           = NUM_CELLS + 1;
    localparam int COL_IDX_W       = $clog2(COL_W);

    localparam int SYM_W           = 5;
    localparam int TOKENS_PER_WORD = 8;
    localparam int SYM_WORD_W      = 40;
    localparam int STAR_W          = 16;
    localparam int TOKEN_COUNT_W   = 5;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 40;

    localparam logic [SYM_W-1:0] ANY_LETTER  = 5'd26;
    localparam logic [SYM_W-1:0] LAST_LETTER = 5'd25;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_CHAR  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SYMBOLS_LOW  = 3'd0,
        REG_SYMBOLS_HIGH = 3'd1,
        REG_STAR_MASK    = 3'd2,
        REG_TOKEN_COUNT  = 3'd3
    } cfg_reg_e;

    // Static description of one token as seen by its cell.
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             starred;
        logic             enabled;
    } cell_cfg_t;

    // The item being applied to the column in this cycle.
    typedef struct packed {
        logic             accept;
        logic             kind;
        logic [SYM_W-1:0] letter;
    } step_t;

    // One result on its way to the output buffer.
    typedef struct packed {
        logic valid;
        logic matched;
    } result_t;

endpackage

`default_nettype wire

>>> sv/wsm_cell.sv
// One token cell of the match column: holds the column bit for its token prefix.
// Depends on wsm_pkg for the cell configuration and step structs.
`default_nettype none

module wsm_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire wsm_pkg::cell_cfg_t cfg,
    input  wire wsm_pkg::step_t    step,
    input  wire logic              left_new,
    input  wire logic              left_old,
    output logic                   self_new,
    output logic                   self_old
);
    import wsm_pkg::*;

    logic bit_reg;
    logic bit_next;
    logic hit;

    assign hit = (cfg.symbol == ANY_LETTER) ||
                 ((cfg.symbol <= LAST_LETTER) && (cfg.symbol == step.letter));

    always_comb begin
        if (!cfg.enabled) begin
            self_new = 1'b0;
        end else if (step.kind == KIND_START) begin
            // Empty text: a starred token may be skipped.
            self_new = cfg.starred && left_new;
        end else if (cfg.starred) begin
            self_new = left_new || (hit && bit_reg);
        end else begin
            self_new = hit && left_old;
        end
    end

    assign bit_next = step.accept ? self_new : bit_reg;
    assign self_old = bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else begin
            bit_reg <= bit_next;
        end
    end

    ap_disabled_cell_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        (step.accept && !cfg.enabled) |=> !bit_reg)
        else $error("disabled token cell kept a set bit");

    ap_hold_when_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        !step.accept |=> (bit_reg == $past(bit_reg)))
        else $error("token cell changed without an item");

    ap_start_not_starred : assert property (@(posedge aclk) disable iff (!aresetn)
        (step.accept && (step.kind == KIND_START) && !cfg.starred) |=> !bit_reg)
        else $error("unstarred token set on an empty text");

endmodule

`default_nettype wire

>>> sv/wsm_out_buf.sv
// Two-entry result buffer with a skid stage, so that a new item can be taken
// while a finished result still waits. Depends on wsm_pkg for result_t.
`default_nettype none

module wsm_out_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire wsm_pkg::result_t push,
    output logic                  in_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_matched
);
    import wsm_pkg::*;

    logic head_valid_reg, head_valid_next;
    logic head_data_reg,  head_data_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_data_reg,  skid_data_next;
    logic pop;

    assign pop       = head_valid_reg && m_ready;
    assign in_ready  = !skid_valid_reg;
    assign m_valid   = head_valid_reg;
    assign m_matched = head_data_reg;

    always_comb begin
        head_valid_next = head_valid_reg;
        head_data_next  = head_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                head_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                head_valid_next = push.valid;
                head_data_next  = push.matched;
            end
        end else if (push.valid) begin
            if (!head_valid_reg) begin
                head_valid_next = 1'b1;
                head_data_next  = push.matched;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push.matched;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_data_reg <= head_data_next;
        skid_data_reg <= skid_data_next;
    end

    ap_skid_behind_head : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held without a head entry");

    ap_no_push_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");

    ap_skid_moves_up : assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && skid_valid_reg) |=> (head_valid_reg && (head_data_reg == $past(skid_data_reg))))
        else $error("skid entry lost on a transfer");

endmodule

`default_nettype wire

>>> sv/wildcard_star_pattern_matcher_top.sv
// Top level of the wildcard star pattern matcher: configuration registers,
// the chain of token cells and the result buffer. Depends on wsm_pkg, wsm_cell, wsm_out_buf.
`default_nettype none

// Matches lowercase text, one character per item, against a pattern of up to 16 tokens
// (a letter or any-letter symbol, optionally starred). A start item (kind 0) begins a new
// empty text; a character item (kind 1) appends a letter. Every item yields one result
// telling whether the text so far matches the whole pattern. An item is taken whenever the
// output buffer has room: the match column is updated in the cycle of the transfer by a single
// ripple through the token cells, each of which holds one column bit, so the throughput is one
// item per cycle while the buffer has room. A two-entry output buffer lets input
// transfers continue while one result waits. The pattern registers are written through
// the cfg port, which is always ready, and should be written only while no item is in flight.
module wildcard_star_pattern_matcher_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [wsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [wsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_kind,
    input  wire logic [wsm_pkg::SYM_W-1:0]          s_letter,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_matched
);
    import wsm_pkg::*;

    logic [SYM_WORD_W-1:0]    symbols_low_reg;
    logic [SYM_WORD_W-1:0]    symbols_high_reg;
    logic [STAR_W-1:0]        star_mask_reg;
    logic [TOKEN_COUNT_W-1:0] token_count_reg;
    logic                     col0_reg;

    logic [COL_IDX_W-1:0]     tokens_used;
    logic [COL_W-1:0]         col_new;
    logic [COL_W-1:0]         col_old;
    step_t                    step;
    result_t                  result;
    logic                     accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
            star_mask_reg    <= '0;
            token_count_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_data;
                REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_data;
                REG_STAR_MASK:    star_mask_reg    <= cfg_data[STAR_W-1:0];
                REG_TOKEN_COUNT:  token_count_reg  <= cfg_data[TOKEN_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Token count saturated to the number of cells that are built.
    assign tokens_used = (token_count_reg > TOKEN_COUNT_W'(NUM_CELLS)) ?
                         COL_IDX_W'(NUM_CELLS) : token_count_reg[COL_IDX_W-1:0];

    assign accept      = s_valid && s_ready;
    assign step.accept = accept;
    assign step.kind   = s_kind;
    assign step.letter = s_letter;

    // The empty prefix matches only the empty text.
    assign col_new[0] = (s_kind == KIND_START);
    assign col_old[0] = col0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col0_reg <= 1'b1;
        end else if (accept) begin
            col0_reg <= col_new[0];
        end
    end

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        cell_cfg_t cell_cfg;

        if (k < TOKENS_PER_WORD) begin : g_low
            assign cell_cfg.symbol = symbols_low_reg[SYM_W*k +: SYM_W];
        end else begin : g_high
            assign cell_cfg.symbol = symbols_high_reg[SYM_W*(k-TOKENS_PER_WORD) +: SYM_W];
        end
        assign cell_cfg.starred = star_mask_reg[k];
        assign cell_cfg.enabled = (tokens_used >= COL_IDX_W'(k + 1));

        wsm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cfg      (cell_cfg),
            .step     (step),
            .left_new (col_new[k]),
            .left_old (col_old[k]),
            .self_new (col_new[k+1]),
            .self_old (col_old[k+1])
        );
    end

    assign result.valid   = accept;
    assign result.matched = col_new[tokens_used];

    wsm_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (result),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_matched (m_matched)
    );

    ap_start_sets_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_kind == KIND_START)) |=> col0_reg)
        else $error("empty prefix not set after a start item");

    ap_char_clears_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_kind == KIND_CHAR)) |=> !col0_reg)
        else $error("empty prefix still set after a character");

    ap_result_follows : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted item produced no pending result");

endmodule

`default_nettype wire
